### rtl/ppg_pkg.sv
package ppg_pkg;

    typedef enum logic [3:0] {
        CMD_TICK       = 4'd0,
        CMD_BTN1       = 4'd1,
        CMD_BTN2       = 4'd2,
        CMD_LEFT       = 4'd3,
        CMD_UP         = 4'd4,
        CMD_RIGHT      = 4'd5,
        CMD_DOWN       = 4'd6,
        CMD_POSITION   = 4'd7,
        CMD_BOTH_BTNS  = 4'd8
    } command_t;

    typedef enum logic [1:0] {
        SPEED_NORMAL = 2'd0,
        SPEED_SLOW   = 2'd1,
        SPEED_FAST   = 2'd2,
        SPEED_NONE   = 2'd3
    } speed_mode_t;

    typedef enum logic [0:0] {
        CFG_DEVICE_CLASS = 1'd0,
        CFG_SPEED_MODE   = 1'd1
    } cfg_index_t;

    localparam int TimerWidth = 26;
    localparam logic [TimerWidth-1:0] PeriodAbs = 26'd33333333;
    localparam logic [TimerWidth-1:0] PeriodRel = 26'd25000000;

    localparam logic [1:0] ClassReset = 2'd1;
    localparam logic [3:0] RunMax     = 4'd15;
    localparam logic [4:0] SpeedNormalMax = 5'd8;
    localparam logic [4:0] SpeedFastMax   = 5'd16;

    localparam int InDataWidth  = 48;
    localparam int OutDataWidth = 32;

endpackage

### rtl/pointer_packet_generator_core.sv
// channel  | valid / ready        | data                 | user
// ---------+----------------------+----------------------+-------------
// s_       | s_tvalid / s_tready  | s_tdata[47:0]        | s_tuser[3:0]
// m_       | m_tvalid / m_tready  | m_tdata[31:0]        | none
// cfg      | cfg_wr_en            | cfg_addr, cfg_wdata  | none
//
// one item per cycle unless m_ stalls; m_ valid is registered after the input register
// an item in the input register updates the state; a packet also loads the output register
// a stalled m_ side stalls the input register, which stops s_tready
// aresetn is synchronous; after reset device_class is relative and speed is normal
module pointer_packet_generator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pressed, tick_ns[23:0], pos_x[9:0], pos_y[9:0], on_area, zero fill
    input  logic [ppg_pkg::InDataWidth-1:0]     s_tdata,
    // command[3:0]
    input  logic [3:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // packet_byte0[6:0], packet_byte1[5:0], packet_byte2[5:0], packet_byte3[5:0], zero fill
    output logic [ppg_pkg::OutDataWidth-1:0]    m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [0:0]                          cfg_addr,
    input  logic [1:0]                          cfg_wdata
);
    import ppg_pkg::*;

    logic                    in_valid_reg;
    logic [3:0]              in_cmd_reg;
    logic                    in_pressed_reg;
    logic [23:0]             in_tick_ns_reg;
    logic [9:0]              in_pos_x_reg;
    logic [9:0]              in_pos_y_reg;
    logic                    in_on_area_reg;

    logic [1:0]              device_class_reg;
    logic [1:0]              speed_mode_reg;

    logic [TimerWidth-1:0]   timer_reg, timer_next;
    logic [3:0]              run_count_reg, run_count_next;
    logic                    pad_left_reg, pad_left_next;
    logic                    pad_up_reg, pad_up_next;
    logic                    pad_right_reg, pad_right_next;
    logic                    pad_down_reg, pad_down_next;
    logic                    btn1_reg, btn1_next;
    logic                    btn2_reg, btn2_next;
    logic                    pd_reg, pd_next;
    logic [10:0]             cur_x_reg, cur_x_next;
    logic [10:0]             cur_y_reg, cur_y_next;
    logic [23:0]             snap_reg, snap_next;

    logic                    m_valid_reg, m_valid_next;
    logic [OutDataWidth-1:0] m_data_reg, m_data_next;

    logic                    advance;
    logic                    work;
    logic                    is_abs;
    logic [TimerWidth-1:0]   period;
    logic [TimerWidth:0]     t_sum;
    logic                    period_hit;
    logic                    any_pad;
    logic [3:0]              run_inc;
    logic [4:0]              speed;
    logic [5:0]              speed_raw;
    logic signed [11:0]      speed_pos;
    logic signed [11:0]      speed_neg;
    logic signed [11:0]      last_x;
    logic signed [11:0]      last_y;
    logic                    clear_x;
    logic                    clear_y;
    logic                    upd;
    logic [10:0]             tick_x;
    logic [10:0]             tick_y;
    logic [6:0]              byte0;
    logic [5:0]              byte1;
    logic [5:0]              byte2;
    logic [5:0]              byte3;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign work     = in_valid_reg && advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // tick evaluation
    always_comb begin
        is_abs     = device_class_reg[1];
        period     = is_abs ? PeriodAbs : PeriodRel;
        t_sum      = {1'b0, timer_reg} + {3'b000, in_tick_ns_reg};
        period_hit = t_sum >= {1'b0, period};
        any_pad    = pad_left_reg || pad_up_reg || pad_right_reg || pad_down_reg;
        run_inc    = !any_pad ? 4'd0
                   : (run_count_reg == RunMax) ? RunMax : run_count_reg + 4'd1;

        unique case (speed_mode_t'(speed_mode_reg))
            SPEED_NORMAL: begin
                speed_raw = {2'b00, run_inc} + {5'b00000, run_inc[0]};
                speed     = (speed_raw > {1'b0, SpeedNormalMax}) ? SpeedNormalMax
                                                                 : speed_raw[4:0];
            end
            SPEED_SLOW: begin
                speed_raw = 6'd1;
                speed     = 5'd1;
            end
            SPEED_FAST: begin
                speed_raw = {1'b0, run_inc, 1'b0};
                speed     = (speed_raw > {1'b0, SpeedFastMax}) ? SpeedFastMax
                                                               : speed_raw[4:0];
            end
            default: begin
                speed_raw = 6'd0;
                speed     = 5'd0;
            end
        endcase

        speed_pos = signed'({7'd0, speed});
        speed_neg = -speed_pos;
        last_x    = signed'({snap_reg[10], snap_reg[10:0]});
        last_y    = signed'({snap_reg[21], snap_reg[21:11]});

        clear_x = 1'b0;
        if (pad_left_reg) begin
            tick_x  = speed_neg[10:0];
            clear_x = last_x < speed_neg;
        end else if (pad_right_reg) begin
            tick_x  = speed_pos[10:0];
            clear_x = last_x > speed_pos;
        end else begin
            tick_x  = 11'd0;
        end

        clear_y = 1'b0;
        if (pad_up_reg) begin
            tick_y  = speed_neg[10:0];
            clear_y = last_y < speed_neg;
        end else if (pad_down_reg) begin
            tick_y  = speed_pos[10:0];
            clear_y = last_y > speed_pos;
        end else begin
            tick_y  = 11'd0;
        end

        upd = any_pad || (btn1_reg != snap_reg[22]) || (btn2_reg != snap_reg[23]);

        if (is_abs) begin
            byte0 = {1'b1, btn1_reg, btn2_reg, tick_x[9:6]};
            byte1 = {pd_reg, 1'b0, tick_y[9:6]};
            byte2 = tick_x[5:0];
            byte3 = tick_y[5:0];
        end else begin
            byte0 = {1'b1, btn1_reg, btn2_reg, tick_y[7:6], tick_x[7:6]};
            byte1 = tick_x[5:0];
            byte2 = tick_y[5:0];
            byte3 = 6'd0;
        end
    end

    always_comb begin
        timer_next     = timer_reg;
        run_count_next = run_count_reg;
        pad_left_next  = pad_left_reg;
        pad_up_next    = pad_up_reg;
        pad_right_next = pad_right_reg;
        pad_down_next  = pad_down_reg;
        btn1_next      = btn1_reg;
        btn2_next      = btn2_reg;
        pd_next        = pd_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        snap_next      = snap_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;

        if (work) begin
            unique case (in_cmd_reg)
                CMD_TICK: begin
                    if (!period_hit) begin
                        timer_next = t_sum[TimerWidth-1:0];
                    end else begin
                        timer_next     = t_sum[TimerWidth-1:0] - period;
                        run_count_next = (clear_x || clear_y) ? 4'd0 : run_inc;
                        cur_x_next     = tick_x;
                        cur_y_next     = tick_y;
                        if (upd) begin
                            snap_next    = {btn2_reg, btn1_reg, tick_y, tick_x};
                            m_valid_next = 1'b1;
                            m_data_next  = {7'd0, byte3, byte2, byte1, byte0};
                        end
                    end
                end
                CMD_BTN1: btn1_next = in_pressed_reg;
                CMD_BTN2: btn2_next = in_pressed_reg;
                CMD_LEFT: begin
                    pad_left_next = in_pressed_reg;
                    if (in_pressed_reg) pad_right_next = 1'b0;
                end
                CMD_UP: begin
                    pad_up_next = in_pressed_reg;
                    if (in_pressed_reg) pad_down_next = 1'b0;
                end
                CMD_RIGHT: begin
                    pad_right_next = in_pressed_reg;
                    if (in_pressed_reg) pad_left_next = 1'b0;
                end
                CMD_DOWN: begin
                    pad_down_next = in_pressed_reg;
                    if (in_pressed_reg) pad_up_next = 1'b0;
                end
                CMD_POSITION: begin
                    pd_next    = in_on_area_reg;
                    cur_x_next = {1'b0, in_pos_x_reg};
                    cur_y_next = {1'b0, in_pos_y_reg};
                end
                CMD_BOTH_BTNS: begin
                    btn1_next = in_pressed_reg;
                    btn2_next = in_pressed_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            device_class_reg <= ClassReset;
            speed_mode_reg   <= SPEED_NORMAL;
            timer_reg        <= '0;
            run_count_reg    <= '0;
            pad_left_reg     <= 1'b0;
            pad_up_reg       <= 1'b0;
            pad_right_reg    <= 1'b0;
            pad_down_reg     <= 1'b0;
            btn1_reg         <= 1'b0;
            btn2_reg         <= 1'b0;
            pd_reg           <= 1'b0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            snap_reg         <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            m_valid_reg   <= m_valid_next;
            timer_reg     <= timer_next;
            run_count_reg <= run_count_next;
            pad_left_reg  <= pad_left_next;
            pad_up_reg    <= pad_up_next;
            pad_right_reg <= pad_right_next;
            pad_down_reg  <= pad_down_next;
            btn1_reg      <= btn1_next;
            btn2_reg      <= btn2_next;
            pd_reg        <= pd_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            snap_reg      <= snap_next;
            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_addr))
                    CFG_DEVICE_CLASS: device_class_reg <= cfg_wdata;
                    CFG_SPEED_MODE:   speed_mode_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg     <= s_tuser;
            in_pressed_reg <= s_tdata[0];
            in_tick_ns_reg <= s_tdata[24:1];
            in_pos_x_reg   <= s_tdata[34:25];
            in_pos_y_reg   <= s_tdata[44:35];
            in_on_area_reg <= s_tdata[45];
        end
        m_data_reg <= m_data_next;
    end

endmodule

### dv/pointer_packet_generator_core_tb.sv
`timescale 1ns / 100ps

module pointer_packet_generator_core_tb;

    import ppg_pkg::*;

    localparam logic [3:0] CmdFirstUnused = 4'd9;
    localparam logic [3:0] CmdLastCode    = 4'hF;
    localparam logic [23:0] TickMax       = 24'hFF_FFFF;

    typedef struct packed {
        logic [5:0] b3;
        logic [5:0] b2;
        logic [5:0] b1;
        logic [6:0] b0;
    } packet_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [InDataWidth-1:0]  s_tdata = '0;
    logic [3:0]              s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OutDataWidth-1:0] m_tdata;
    logic                    cfg_wr_en = 1'b0;
    logic [0:0]              cfg_addr = '0;
    logic [1:0]              cfg_wdata = '0;

    // pointer state as seen from outside
    logic [1:0]              model_class = ClassReset;
    speed_mode_t             model_speed = SPEED_NORMAL;
    logic [TimerWidth-1:0]   period_timer = '0;
    logic [3:0]              run_count = '0;
    logic                    pad_left = 1'b0;
    logic                    pad_up = 1'b0;
    logic                    pad_right = 1'b0;
    logic                    pad_down = 1'b0;
    logic                    cur_btn1 = 1'b0;
    logic                    cur_btn2 = 1'b0;
    logic                    cur_pd = 1'b0;
    logic [10:0]             cur_x = '0;
    logic [10:0]             cur_y = '0;
    logic [23:0]             sent_state = '0;

    packet_t                 expected_packets[$];
    packet_t                 want_packet;
    int                      sender_idle_pct = 0;
    int                      receiver_stall_pct = 0;
    bit                      failed = 1'b0;

    pointer_packet_generator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic bit pointer_event(input logic [3:0] cmd, input logic pressed,
                                         input logic [23:0] ns, input logic [9:0] px,
                                         input logic [9:0] py, input logic on_area,
                                         output packet_t pkt);
        int period;
        int t;
        int speed;
        int v;
        int lastx;
        int lasty;
        bit upd;
        pkt = '0;
        upd = 1'b0;
        case (cmd)
            CMD_TICK: begin
                period = (model_class >= 2'd2) ? int'(PeriodAbs) : int'(PeriodRel);
                t = int'(period_timer) + int'(ns);
                if (t < period) begin
                    period_timer = t[TimerWidth-1:0];
                    return 1'b0;
                end
                t = t - period;
                period_timer = t[TimerWidth-1:0];
                if (!(pad_left || pad_up || pad_right || pad_down)) begin
                    run_count = '0;
                end else if (run_count != RunMax) begin
                    run_count = run_count + 4'd1;
                end
                case (model_speed)
                    SPEED_NORMAL: begin
                        speed = int'(run_count) + int'(run_count[0]);
                        if (speed > int'(SpeedNormalMax)) speed = int'(SpeedNormalMax);
                    end
                    SPEED_SLOW: speed = 1;
                    SPEED_FAST: begin
                        speed = 2 * int'(run_count);
                        if (speed > int'(SpeedFastMax)) speed = int'(SpeedFastMax);
                    end
                    default: speed = 0;
                endcase
                lastx = int'($signed(sent_state[10:0]));
                lasty = int'($signed(sent_state[21:11]));
                if (pad_left) begin
                    v = -speed;
                    cur_x = v[10:0];
                    upd = 1'b1;
                    if (lastx < v) run_count = '0;
                end else if (pad_right) begin
                    v = speed;
                    cur_x = v[10:0];
                    upd = 1'b1;
                    if (lastx > v) run_count = '0;
                end else begin
                    cur_x = '0;
                end
                if (pad_up) begin
                    v = -speed;
                    cur_y = v[10:0];
                    upd = 1'b1;
                    if (lasty < v) run_count = '0;
                end else if (pad_down) begin
                    v = speed;
                    cur_y = v[10:0];
                    upd = 1'b1;
                    if (lasty > v) run_count = '0;
                end else begin
                    cur_y = '0;
                end
                if (cur_btn1 != sent_state[22]) upd = 1'b1;
                if (cur_btn2 != sent_state[23]) upd = 1'b1;
                if (!upd) return 1'b0;
                if (model_class >= 2'd2) begin
                    pkt.b0 = {1'b1, cur_btn1, cur_btn2, cur_x[9:6]};
                    pkt.b1 = {cur_pd, 1'b0, cur_y[9:6]};
                    pkt.b2 = cur_x[5:0];
                    pkt.b3 = cur_y[5:0];
                end else begin
                    pkt.b0 = {1'b1, cur_btn1, cur_btn2, cur_y[7:6], cur_x[7:6]};
                    pkt.b1 = cur_x[5:0];
                    pkt.b2 = cur_y[5:0];
                    pkt.b3 = '0;
                end
                sent_state = {cur_btn2, cur_btn1, cur_y, cur_x};
                return 1'b1;
            end
            CMD_BTN1: cur_btn1 = pressed;
            CMD_BTN2: cur_btn2 = pressed;
            CMD_LEFT: begin
                pad_left = pressed;
                if (pressed) pad_right = 1'b0;
            end
            CMD_UP: begin
                pad_up = pressed;
                if (pressed) pad_down = 1'b0;
            end
            CMD_RIGHT: begin
                pad_right = pressed;
                if (pressed) pad_left = 1'b0;
            end
            CMD_DOWN: begin
                pad_down = pressed;
                if (pressed) pad_up = 1'b0;
            end
            CMD_POSITION: begin
                cur_pd = on_area;
                cur_x = {1'b0, px};
                cur_y = {1'b0, py};
            end
            CMD_BOTH_BTNS: begin
                cur_btn1 = pressed;
                cur_btn2 = pressed;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // receiver side
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_packets.size() == 0) begin
                $error("packet with none expected: m_tdata %0h", m_tdata);
                failed = 1'b1;
            end else begin
                want_packet = expected_packets.pop_front();
                if (m_tdata[6:0] !== want_packet.b0) begin
                    $error("packet_byte0: expected %0h, actual %0h", want_packet.b0, m_tdata[6:0]);
                    failed = 1'b1;
                end
                if (m_tdata[12:7] !== want_packet.b1) begin
                    $error("packet_byte1: expected %0h, actual %0h", want_packet.b1, m_tdata[12:7]);
                    failed = 1'b1;
                end
                if (m_tdata[18:13] !== want_packet.b2) begin
                    $error("packet_byte2: expected %0h, actual %0h", want_packet.b2, m_tdata[18:13]);
                    failed = 1'b1;
                end
                if (m_tdata[24:19] !== want_packet.b3) begin
                    $error("packet_byte3: expected %0h, actual %0h", want_packet.b3, m_tdata[24:19]);
                    failed = 1'b1;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [3:0] cmd, input logic pressed, input logic [23:0] ns,
                             input logic [9:0] px, input logic [9:0] py, input logic on_area);
        packet_t pkt;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, on_area, py, px, ns, pressed};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (pointer_event(cmd, pressed, ns, px, py, on_area, pkt)) begin
            expected_packets.push_back(pkt);
        end
        @(negedge aclk);
    endtask

    task automatic send_random_item();
        logic [3:0]  cmd;
        logic        pressed;
        logic [23:0] ns;
        int          roll;
        roll = $urandom_range(99);
        pressed = 1'($urandom_range(1));
        ns = 24'($urandom);
        if (roll < 45) begin
            cmd = CMD_TICK;
            case ($urandom_range(9))
                0: ns = TickMax;
                1: ns = '0;
                2: ns = 24'($urandom_range(1000));
                default: ;
            endcase
        end else if (roll < 80) begin
            cmd = 4'(CMD_LEFT + $urandom_range(3));
            pressed = ($urandom_range(9) < 6);
        end else if (roll < 88) begin
            case ($urandom_range(2))
                0: cmd = CMD_BTN1;
                1: cmd = CMD_BTN2;
                default: cmd = CMD_BOTH_BTNS;
            endcase
        end else if (roll < 95) begin
            cmd = CMD_POSITION;
        end else begin
            cmd = 4'($urandom_range(CmdFirstUnused, CmdLastCode));
        end
        send_item(cmd, pressed, ns, 10'($urandom), 10'($urandom), 1'($urandom_range(1)));
    endtask

    // lets the pipeline empty, including items that cause no packet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_packets.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_DEVICE_CLASS: model_class = value;
            default: model_speed = speed_mode_t'(value);
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic test_directed();
        send_item(CMD_TICK, 1'b1, '0, 10'h3FF, 10'h3FF, 1'b1);
        send_item(CMD_TICK, 1'b0, TickMax, '0, '0, 1'b0);
        send_item(CMD_BTN1, 1'b1, '0, '0, '0, 1'b0);
        send_item(CMD_TICK, 1'b0, TickMax, '0, '0, 1'b0);
        send_item(CMD_BOTH_BTNS, 1'b1, TickMax, 10'h3FF, 10'h3FF, 1'b1);
        send_item(CMD_POSITION, 1'b1, TickMax, 10'h3FF, 10'h3FF, 1'b1);
        send_item(CMD_LEFT, 1'b1, '0, '0, '0, 1'b0);
        send_item(CMD_UP, 1'b1, '0, '0, '0, 1'b0);
        send_item(CMD_TICK, 1'b0, TickMax, '0, '0, 1'b0);
        send_item(CMD_TICK, 1'b0, TickMax, '0, '0, 1'b0);
        // opposite directions release the held ones
        send_item(CMD_RIGHT, 1'b1, '0, '0, '0, 1'b0);
        send_item(CMD_DOWN, 1'b1, '0, '0, '0, 1'b0);
        send_item(CMD_TICK, 1'b0, TickMax, '0, '0, 1'b0);
        send_item(CMD_TICK, 1'b0, TickMax, '0, '0, 1'b0);
        send_item(CMD_RIGHT, 1'b0, '0, '0, '0, 1'b0);
        send_item(CMD_DOWN, 1'b0, '0, '0, '0, 1'b0);
        send_item(CMD_BTN2, 1'b0, '0, '0, '0, 1'b0);
        send_item(CMD_BTN1, 1'b0, '0, '0, '0, 1'b0);
        send_item(CMD_TICK, 1'b0, TickMax, '0, '0, 1'b0);
        send_item(CMD_TICK, 1'b0, TickMax, '0, '0, 1'b0);
        // unused codes are ignored
        send_item(CmdLastCode, 1'b1, TickMax, 10'h3FF, 10'h3FF, 1'b1);
        send_item(CmdFirstUnused, 1'b0, '0, '0, '0, 1'b0);
        send_item(CMD_POSITION, 1'b0, '0, '0, '0, 1'b0);
        send_item(CMD_TICK, 1'b0, TickMax, '0, '0, 1'b0);
        send_item(CMD_TICK, 1'b0, TickMax, '0, '0, 1'b0);
        settle();
    endtask

    // every class with every speed mode, held diagonal long enough to saturate the speed
    task automatic test_config_sweep();
        for (int c = 0; c < 4; c++) begin
            for (int s = 0; s < 4; s++) begin
                settle();
                write_register(CFG_DEVICE_CLASS, c[1:0]);
                write_register(CFG_SPEED_MODE, s[1:0]);
                send_item(CMD_LEFT, 1'b1, 24'($urandom), 10'($urandom), 10'($urandom),
                          1'($urandom_range(1)));
                send_item(CMD_DOWN, 1'b1, 24'($urandom), 10'($urandom), 10'($urandom),
                          1'($urandom_range(1)));
                repeat (28) send_item(CMD_TICK, 1'($urandom_range(1)), TickMax, 10'($urandom),
                                      10'($urandom), 1'($urandom_range(1)));
                repeat (12) send_random_item();
            end
        end
        settle();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count,
                                       input bit drain_midway);
        settle();
        write_register(CFG_DEVICE_CLASS, 2'($urandom_range(3)));
        write_register(CFG_SPEED_MODE, 2'($urandom_range(3)));
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (drain_midway && i == count / 2) begin
                settle();
            end
            send_random_item();
        end
        settle();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_config_sweep();
        test_random_traffic(0, 0, 310, 1'b0);
        test_random_traffic(46, 0, 310, 1'b1);
        test_random_traffic(0, 46, 310, 1'b0);
        test_random_traffic(15, 15, 310, 1'b0);
        if (!failed && expected_packets.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
